@@ rtl/max_flow_dinic_core_defines.svh @@
// ---------------------------------------------------------------------------
// max_flow_dinic_core_defines
// assertion macros of the max flow core
// ---------------------------------------------------------------------------
`ifndef MAX_FLOW_DINIC_CORE_DEFINES_SVH
`define MAX_FLOW_DINIC_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock edge out of reset
`define MFD_ASSERT(label, c, r, expr, msg) \
    label: assert property (@(posedge c) disable iff (!r) (expr)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define MFD_ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);
`else
`define MFD_ASSERT(label, c, r, expr, msg)
`define MFD_ASSERT_NEXT(label, c, r, ante, cons, msg)
`endif
`endif

@@ rtl/mfd_pkg.sv @@
// ---------------------------------------------------------------------------
// mfd_pkg
// types and constants of the max flow core
// ---------------------------------------------------------------------------
package mfd_pkg;

    localparam int MAX_NODES_DEF = 128;
    localparam int MAX_EDGES_DEF = 1024;

    localparam int CAP_W   = 16;
    localparam int NODE_FW = 7;
    localparam int TOTAL_W = 26;
    localparam int CFG_W   = 8;
    localparam int FLOW_W  = 17;

    localparam logic [TOTAL_W-1:0] FLOW_MAX      = 26'h3FFFFFF;
    localparam logic [CFG_W-1:0]   NODE_CNT_INIT = 8'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FLOW = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [NODE_FW-1:0] edge_from;
        logic [NODE_FW-1:0] edge_to;
        logic [CAP_W-1:0]   edge_capacity;
    } in_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] max_flow;
        logic               edges_dropped;
    } out_item_t;

endpackage

@@ rtl/max_flow_dinic_core.sv @@
// ---------------------------------------------------------------------------
// max_flow_dinic_core
// dinic maximum flow from node 0 to node node_count-1 over a loaded edge table
// ---------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_data): a request with cmd add stores
//   one edge plus its zero capacity reverse twin; cmd flow runs the max flow,
//   returns one result and empties the edge table and the drop flag
//   out channel (out_valid / out_stall / out_data): one result per flow request
//   cfg channel (cfg_valid / cfg_ready / cfg_data): node_count, always ready,
//   write it only while the core is idle
// request handling
//   an add request holds the core while it does two reads and two writes of
//   the list head ram, linking both entries into their adjacency lists
//   a flow request takes a data dependent time: each level pass inits the
//   level table, dequeues nodes and scans their edges, copies the current
//   arcs, then takes arc steps and retreats and augments along each path;
//   each ram has a single read port, so these steps run one after another
// reset and stall
//   reset empties the table, clears the drop flag and sets node_count to 2
//   a finished result sits in the output register; add requests are still
//   taken while it waits, a second flow result waits until the first is taken
// ---------------------------------------------------------------------------
`include "max_flow_dinic_core_defines.svh"

module max_flow_dinic_core #(
    parameter int MAX_NODES = mfd_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mfd_pkg::MAX_EDGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  mfd_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output mfd_pkg::out_item_t         out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mfd_pkg::CFG_W-1:0]  cfg_data
);

    localparam int ENTRIES = 2 * MAX_EDGES;
    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int ENTRY_W = $clog2(ENTRIES);
    localparam int NCNT_W  = NODE_W + 1;    // holds a node count
    localparam int LINK_W  = ENTRY_W + 1;   // entry index plus empty marker bit
    localparam int LEV_W   = NODE_W + 1;
    localparam int CAP_W   = mfd_pkg::CAP_W;
    localparam int FLOW_W  = mfd_pkg::FLOW_W;
    localparam int EDGE_W  = LINK_W + NODE_W + CAP_W;
    localparam int TOTAL_W = mfd_pkg::TOTAL_W;

    localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {ENTRY_W{1'b0}}};
    localparam logic [LEV_W-1:0]  UNSEEN    = {LEV_W{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE, ST_E_RD, ST_E_FWD, ST_E_REV,
        ST_LV_INIT, ST_B_POP, ST_B_POP2, ST_B_HEAD, ST_B_EDGE, ST_B_CHK1, ST_B_CHK2,
        ST_A_RD, ST_A_WR,
        ST_D_START, ST_D_STEP, ST_D_ARC, ST_D_ARC2, ST_D_ARC3,
        ST_D_POP1, ST_D_POP2, ST_D_POP3, ST_D_POP4,
        ST_P_MIN, ST_P_MIN1, ST_P_MIN2, ST_P_ADD, ST_P_ADD1, ST_P_ADD2, ST_P_ADD3,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [mfd_pkg::CFG_W-1:0] node_count_reg;
    logic [ENTRY_W:0]         edge_total_reg;
    logic                     overflow_reg;
    logic [MAX_NODES-1:0]     fv_reg;        // list head valid bits
    logic [NCNT_W-1:0]        n_reg;
    logic [NODE_W-1:0]        sink_reg;
    logic [NODE_W-1:0]        from_reg;
    logic [NODE_W-1:0]        to_reg;
    logic [CAP_W-1:0]         cap_reg;
    logic [NCNT_W-1:0]        i_reg;
    logic [NCNT_W-1:0]        q_head_reg;
    logic [NCNT_W-1:0]        q_tail_reg;
    logic [NODE_W-1:0]        v_reg;
    logic [LEV_W-1:0]         vlev_reg;
    logic [LINK_W-1:0]        id_reg;
    logic [LINK_W-1:0]        link_reg;
    logic                     res_pos_reg;
    logic                     found_reg;
    logic [NCNT_W-1:0]        depth_reg;
    logic [NCNT_W-1:0]        k_reg;
    logic [CAP_W-1:0]         push_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     out_valid_reg;
    mfd_pkg::out_item_t       out_reg;

    // ram ports
    logic                     edge_we;
    logic [ENTRY_W-1:0]       edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]        edge_wdata, edge_rdata;
    logic                     flow_we;
    logic [ENTRY_W-1:0]       flow_waddr, flow_raddr;
    logic [FLOW_W-1:0]        flow_wdata, flow_rdata;
    logic                     first_we;
    logic [NODE_W-1:0]        first_waddr, first_raddr;
    logic [ENTRY_W-1:0]       first_wdata, first_rdata;
    logic                     level_we;
    logic [NODE_W-1:0]        level_waddr, level_raddr;
    logic [LEV_W-1:0]         level_wdata, level_rdata;
    logic                     arc_we;
    logic [NODE_W-1:0]        arc_waddr, arc_raddr;
    logic [LINK_W-1:0]        arc_wdata, arc_rdata;
    logic                     queue_we;
    logic [NODE_W-1:0]        queue_waddr, queue_raddr;
    logic [NODE_W-1:0]        queue_wdata, queue_rdata;
    logic                     stack_we;
    logic [NODE_W-1:0]        stack_waddr, stack_raddr;
    logic [ENTRY_W-1:0]       stack_wdata, stack_rdata;

    // decoded edge entry and the shared residual unit
    logic [LINK_W-1:0]        e_link;
    logic [NODE_W-1:0]        e_head;
    logic [CAP_W-1:0]         e_cap;
    logic signed [FLOW_W:0]   res;
    logic                     res_pos;
    logic [TOTAL_W:0]         total_sum;

    logic [NCNT_W-1:0]        n_clamp;
    logic [NODE_W-1:0]        in_from_n, in_to_n;
    logic [ENTRY_W-1:0]       et_lo, et_lo1;
    logic                     in_acc, in_ok, tbl_full, fin_go;

    assign e_link    = edge_rdata[EDGE_W-1 -: LINK_W];
    assign e_head    = edge_rdata[CAP_W +: NODE_W];
    assign e_cap     = edge_rdata[CAP_W-1:0];
    assign res       = $signed({2'b00, e_cap}) - $signed({flow_rdata[FLOW_W-1], flow_rdata});
    assign res_pos   = !res[FLOW_W] && (res != '0);
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(push_reg);

    assign in_from_n = NODE_W'(in_data.edge_from);
    assign in_to_n   = NODE_W'(in_data.edge_to);
    assign et_lo     = edge_total_reg[ENTRY_W-1:0];
    assign et_lo1    = et_lo | ENTRY_W'(1);
    assign in_acc    = in_valid && !in_stall;
    assign in_ok     = (32'(in_data.edge_from) < MAX_NODES) && (32'(in_data.edge_to) < MAX_NODES);
    assign tbl_full  = (32'(edge_total_reg) + 2) > ENTRIES;
    assign fin_go    = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // out of range node counts act as the nearest legal count
    always_comb
    begin
        if (32'(node_count_reg) < 2)
            n_clamp = NCNT_W'(2);
        else if (32'(node_count_reg) > MAX_NODES)
            n_clamp = NCNT_W'(MAX_NODES);
        else
            n_clamp = NCNT_W'(node_count_reg);
    end

    // ram port steering per sequencer step
    always_comb
    begin
        edge_we     = 1'b0;
        edge_waddr  = et_lo;
        edge_wdata  = '0;
        edge_raddr  = id_reg[ENTRY_W-1:0];
        flow_we     = 1'b0;
        flow_waddr  = et_lo;
        flow_wdata  = '0;
        flow_raddr  = id_reg[ENTRY_W-1:0];
        first_we    = 1'b0;
        first_waddr = from_reg;
        first_wdata = et_lo;
        first_raddr = from_reg;
        level_we    = 1'b0;
        level_waddr = i_reg[NODE_W-1:0];
        level_wdata = UNSEEN;
        level_raddr = v_reg;
        arc_we      = 1'b0;
        arc_waddr   = v_reg;
        arc_wdata   = link_reg;
        arc_raddr   = v_reg;
        queue_we    = 1'b0;
        queue_waddr = q_tail_reg[NODE_W-1:0];
        queue_wdata = to_reg;
        queue_raddr = q_head_reg[NODE_W-1:0];
        stack_we    = 1'b0;
        stack_waddr = depth_reg[NODE_W-1:0];
        stack_wdata = id_reg[ENTRY_W-1:0];
        stack_raddr = k_reg[NODE_W-1:0];
        case (state_reg)
            ST_E_RD:
            begin
                first_raddr = from_reg;
            end
            ST_E_FWD:
            begin
                // forward entry links in front of the tail's list
                edge_we     = 1'b1;
                edge_waddr  = et_lo;
                edge_wdata  = {(fv_reg[from_reg] ? {1'b0, first_rdata} : LINK_NONE),
                               to_reg, cap_reg};
                flow_we     = 1'b1;
                flow_waddr  = et_lo;
                first_we    = 1'b1;
                first_waddr = from_reg;
                first_wdata = et_lo;
                first_raddr = to_reg;
            end
            ST_E_REV:
            begin
                // self loop: the head just written is not in the read data yet
                edge_we     = 1'b1;
                edge_waddr  = et_lo1;
                edge_wdata  = {((to_reg == from_reg) ? {1'b0, et_lo} :
                                (fv_reg[to_reg] ? {1'b0, first_rdata} : LINK_NONE)),
                               from_reg, {CAP_W{1'b0}}};
                flow_we     = 1'b1;
                flow_waddr  = et_lo1;
                first_we    = 1'b1;
                first_waddr = to_reg;
                first_wdata = et_lo1;
            end
            ST_LV_INIT:
            begin
                level_we    = 1'b1;
                level_waddr = i_reg[NODE_W-1:0];
                level_wdata = (i_reg == '0) ? '0 : UNSEEN;
                queue_we    = (i_reg == '0);
                queue_waddr = '0;
                queue_wdata = '0;
            end
            ST_B_POP:
            begin
                queue_raddr = q_head_reg[NODE_W-1:0];
            end
            ST_B_POP2:
            begin
                first_raddr = queue_rdata;
                level_raddr = queue_rdata;
            end
            ST_B_EDGE:
            begin
                edge_raddr = id_reg[ENTRY_W-1:0];
                flow_raddr = id_reg[ENTRY_W-1:0];
            end
            ST_B_CHK1:
            begin
                level_raddr = e_head;
            end
            ST_B_CHK2:
            begin
                if ((level_rdata == UNSEEN) && res_pos_reg && ({1'b0, to_reg} < n_reg)
                    && (q_tail_reg < NCNT_W'(MAX_NODES)))
                begin
                    level_we    = 1'b1;
                    level_waddr = to_reg;
                    level_wdata = vlev_reg + LEV_W'(1);
                    queue_we    = 1'b1;
                end
            end
            ST_A_RD:
            begin
                first_raddr = i_reg[NODE_W-1:0];
            end
            ST_A_WR:
            begin
                arc_we    = 1'b1;
                arc_waddr = i_reg[NODE_W-1:0];
                arc_wdata = fv_reg[i_reg[NODE_W-1:0]] ? {1'b0, first_rdata} : LINK_NONE;
            end
            ST_D_STEP:
            begin
                arc_raddr = v_reg;
            end
            ST_D_ARC:
            begin
                edge_raddr  = arc_rdata[ENTRY_W-1:0];
                flow_raddr  = arc_rdata[ENTRY_W-1:0];
                stack_raddr = depth_reg[NODE_W-1:0] - NODE_W'(1);
            end
            ST_D_ARC2:
            begin
                level_raddr = e_head;
            end
            ST_D_ARC3:
            begin
                if ((level_rdata == vlev_reg + LEV_W'(1)) && res_pos_reg
                    && ({1'b0, to_reg} < n_reg) && (depth_reg < NCNT_W'(MAX_NODES)))
                begin
                    stack_we = 1'b1;
                end
                else
                begin
                    arc_we = 1'b1;
                end
            end
            ST_D_POP1:
            begin
                edge_raddr = stack_rdata ^ ENTRY_W'(1);
            end
            ST_D_POP2:
            begin
                arc_raddr = e_head;
            end
            ST_D_POP3:
            begin
                edge_raddr = arc_rdata[ENTRY_W-1:0];
            end
            ST_D_POP4:
            begin
                arc_we    = 1'b1;
                arc_wdata = e_link;
            end
            ST_P_MIN, ST_P_ADD:
            begin
                stack_raddr = k_reg[NODE_W-1:0];
            end
            ST_P_MIN1:
            begin
                edge_raddr = stack_rdata;
                flow_raddr = stack_rdata;
            end
            ST_P_ADD1:
            begin
                flow_raddr = stack_rdata;
            end
            ST_P_ADD2:
            begin
                flow_we    = 1'b1;
                flow_waddr = id_reg[ENTRY_W-1:0];
                flow_wdata = flow_rdata + FLOW_W'(push_reg);
                flow_raddr = id_reg[ENTRY_W-1:0] ^ ENTRY_W'(1);
            end
            ST_P_ADD3:
            begin
                flow_we    = 1'b1;
                flow_waddr = id_reg[ENTRY_W-1:0] ^ ENTRY_W'(1);
                flow_wdata = flow_rdata - FLOW_W'(push_reg);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and all registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= mfd_pkg::NODE_CNT_INIT;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            fv_reg         <= '0;
            n_reg          <= '0;
            sink_reg       <= '0;
            from_reg       <= '0;
            to_reg         <= '0;
            cap_reg        <= '0;
            i_reg          <= '0;
            q_head_reg     <= '0;
            q_tail_reg     <= '0;
            v_reg          <= '0;
            vlev_reg       <= '0;
            id_reg         <= '0;
            link_reg       <= '0;
            res_pos_reg    <= 1'b0;
            found_reg      <= 1'b0;
            depth_reg      <= '0;
            k_reg          <= '0;
            push_reg       <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        from_reg <= in_from_n;
                        to_reg   <= in_to_n;
                        cap_reg  <= in_data.edge_capacity;
                        if (in_data.cmd == mfd_pkg::CMD_FLOW)
                        begin
                            n_reg     <= n_clamp;
                            sink_reg  <= NODE_W'(n_clamp - NCNT_W'(1));
                            total_reg <= '0;
                            i_reg     <= '0;
                            state_reg <= ST_LV_INIT;
                        end
                        else if (in_ok)
                        begin
                            if (tbl_full)
                                overflow_reg <= 1'b1;
                            else
                                state_reg <= ST_E_RD;
                        end
                    end
                end
                ST_E_RD:
                begin
                    state_reg <= ST_E_FWD;
                end
                ST_E_FWD:
                begin
                    fv_reg[from_reg] <= 1'b1;
                    state_reg        <= ST_E_REV;
                end
                ST_E_REV:
                begin
                    fv_reg[to_reg] <= 1'b1;
                    edge_total_reg <= edge_total_reg + (ENTRY_W + 1)'(2);
                    state_reg      <= ST_IDLE;
                end
                // level pass
                ST_LV_INIT:
                begin
                    if (i_reg == n_reg - NCNT_W'(1))
                    begin
                        q_head_reg <= '0;
                        q_tail_reg <= NCNT_W'(1);
                        found_reg  <= 1'b0;
                        state_reg  <= ST_B_POP;
                    end
                    else
                    begin
                        i_reg <= i_reg + NCNT_W'(1);
                    end
                end
                ST_B_POP:
                begin
                    if ((q_head_reg < q_tail_reg) && !found_reg)
                    begin
                        q_head_reg <= q_head_reg + NCNT_W'(1);
                        state_reg  <= ST_B_POP2;
                    end
                    else if (found_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_A_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_B_POP2:
                begin
                    v_reg     <= queue_rdata;
                    state_reg <= ST_B_HEAD;
                end
                ST_B_HEAD:
                begin
                    vlev_reg  <= level_rdata;
                    id_reg    <= fv_reg[v_reg] ? {1'b0, first_rdata} : LINK_NONE;
                    state_reg <= ST_B_EDGE;
                end
                ST_B_EDGE:
                begin
                    state_reg <= id_reg[ENTRY_W] ? ST_B_POP : ST_B_CHK1;
                end
                ST_B_CHK1:
                begin
                    to_reg      <= e_head;
                    link_reg    <= e_link;
                    res_pos_reg <= res_pos;
                    state_reg   <= ST_B_CHK2;
                end
                ST_B_CHK2:
                begin
                    if ((level_rdata == UNSEEN) && res_pos_reg && ({1'b0, to_reg} < n_reg)
                        && (q_tail_reg < NCNT_W'(MAX_NODES)))
                    begin
                        q_tail_reg <= q_tail_reg + NCNT_W'(1);
                        if (to_reg == sink_reg)
                            found_reg <= 1'b1;
                    end
                    id_reg    <= link_reg;
                    state_reg <= ST_B_EDGE;
                end
                // current arcs start at the list heads
                ST_A_RD:
                begin
                    state_reg <= ST_A_WR;
                end
                ST_A_WR:
                begin
                    if (i_reg == n_reg - NCNT_W'(1))
                    begin
                        state_reg <= ST_D_START;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NCNT_W'(1);
                        state_reg <= ST_A_RD;
                    end
                end
                // augmenting walk from the source
                ST_D_START:
                begin
                    v_reg     <= '0;
                    vlev_reg  <= '0;
                    depth_reg <= '0;
                    state_reg <= ST_D_STEP;
                end
                ST_D_STEP:
                begin
                    if (v_reg == sink_reg)
                    begin
                        k_reg     <= '0;
                        push_reg  <= '1;
                        state_reg <= ST_P_MIN;
                    end
                    else
                    begin
                        state_reg <= ST_D_ARC;
                    end
                end
                ST_D_ARC:
                begin
                    if (!arc_rdata[ENTRY_W])
                    begin
                        id_reg    <= arc_rdata;
                        state_reg <= ST_D_ARC2;
                    end
                    else if (depth_reg == '0)
                    begin
                        // blocking flow done, next level pass
                        i_reg     <= '0;
                        state_reg <= ST_LV_INIT;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - NCNT_W'(1);
                        state_reg <= ST_D_POP1;
                    end
                end
                ST_D_ARC2:
                begin
                    to_reg      <= e_head;
                    link_reg    <= e_link;
                    res_pos_reg <= res_pos;
                    state_reg   <= ST_D_ARC3;
                end
                ST_D_ARC3:
                begin
                    if ((level_rdata == vlev_reg + LEV_W'(1)) && res_pos_reg
                        && ({1'b0, to_reg} < n_reg) && (depth_reg < NCNT_W'(MAX_NODES)))
                    begin
                        depth_reg <= depth_reg + NCNT_W'(1);
                        v_reg     <= to_reg;
                        vlev_reg  <= vlev_reg + LEV_W'(1);
                    end
                    state_reg <= ST_D_STEP;
                end
                // retreat: tail of the popped edge, skip its arc
                ST_D_POP1:
                begin
                    state_reg <= ST_D_POP2;
                end
                ST_D_POP2:
                begin
                    v_reg     <= e_head;
                    vlev_reg  <= vlev_reg - LEV_W'(1);
                    state_reg <= ST_D_POP3;
                end
                ST_D_POP3:
                begin
                    state_reg <= ST_D_POP4;
                end
                ST_D_POP4:
                begin
                    state_reg <= ST_D_STEP;
                end
                // bottleneck over the path
                ST_P_MIN:
                begin
                    state_reg <= ST_P_MIN1;
                end
                ST_P_MIN1:
                begin
                    state_reg <= ST_P_MIN2;
                end
                ST_P_MIN2:
                begin
                    if (res[CAP_W-1:0] < push_reg)
                        push_reg <= res[CAP_W-1:0];
                    if (k_reg + NCNT_W'(1) < depth_reg)
                    begin
                        k_reg     <= k_reg + NCNT_W'(1);
                        state_reg <= ST_P_MIN;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_P_ADD;
                    end
                end
                // push along the path and its twins
                ST_P_ADD:
                begin
                    state_reg <= ST_P_ADD1;
                end
                ST_P_ADD1:
                begin
                    id_reg    <= {1'b0, stack_rdata};
                    state_reg <= ST_P_ADD2;
                end
                ST_P_ADD2:
                begin
                    state_reg <= ST_P_ADD3;
                end
                ST_P_ADD3:
                begin
                    if (k_reg + NCNT_W'(1) < depth_reg)
                    begin
                        k_reg     <= k_reg + NCNT_W'(1);
                        state_reg <= ST_P_ADD;
                    end
                    else
                    begin
                        // saturating total
                        if (total_sum > (TOTAL_W + 1)'(mfd_pkg::FLOW_MAX))
                            total_reg <= mfd_pkg::FLOW_MAX;
                        else
                            total_reg <= total_sum[TOTAL_W-1:0];
                        state_reg <= ST_D_START;
                    end
                end
                ST_FINISH:
                begin
                    if (fin_go)
                    begin
                        out_reg.max_flow      <= total_reg;
                        out_reg.edges_dropped <= overflow_reg;
                        out_valid_reg         <= 1'b1;
                        fv_reg                <= '0;
                        edge_total_reg        <= '0;
                        overflow_reg          <= 1'b0;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    mfd_ram #(.W(EDGE_W), .D(ENTRIES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    mfd_ram #(.W(FLOW_W), .D(ENTRIES)) u_flow_ram (
        .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .raddr(flow_raddr), .rdata(flow_rdata)
    );

    mfd_ram #(.W(ENTRY_W), .D(MAX_NODES)) u_first_ram (
        .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
        .raddr(first_raddr), .rdata(first_rdata)
    );

    mfd_ram #(.W(LEV_W), .D(MAX_NODES)) u_level_ram (
        .clk(clk), .we(level_we), .waddr(level_waddr), .wdata(level_wdata),
        .raddr(level_raddr), .rdata(level_rdata)
    );

    mfd_ram #(.W(LINK_W), .D(MAX_NODES)) u_arc_ram (
        .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
        .raddr(arc_raddr), .rdata(arc_rdata)
    );

    mfd_ram #(.W(NODE_W), .D(MAX_NODES)) u_queue_ram (
        .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );

    mfd_ram #(.W(ENTRY_W), .D(MAX_NODES)) u_stack_ram (
        .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .raddr(stack_raddr), .rdata(stack_rdata)
    );

    // checks
    `MFD_ASSERT(a_depth_bound, clk, rst_n, depth_reg <= NCNT_W'(MAX_NODES), "path deeper than node limit")
    `MFD_ASSERT(a_queue_order, clk, rst_n, q_head_reg <= q_tail_reg, "queue head passed tail")
    `MFD_ASSERT(a_table_even, clk, rst_n, !edge_total_reg[0] && (32'(edge_total_reg) <= ENTRIES), "edge count odd or beyond table")
    `MFD_ASSERT_NEXT(a_clear_after, clk, rst_n, (state_reg == ST_FINISH) && fin_go, out_valid_reg && (edge_total_reg == '0) && !overflow_reg && (fv_reg == '0), "graph not cleared with result")

endmodule

@@ rtl/mfd_ram.sv @@
// ---------------------------------------------------------------------------
// mfd_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module mfd_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
